>>> rtl/core/hcl_pkg.sv
// shared constants and types for the huffman code length histogram
// no dependencies; used by huffman_code_length_histogram and its testbench
package hcl_pkg;

    localparam int MAX_SYMBOLS = 256;
    localparam int MAX_DEPTH   = 64;

    localparam int NODE_SLOTS = MAX_SYMBOLS - 1;
    localparam int NODE_W     = $clog2(NODE_SLOTS);
    localparam int LOAD_W     = $clog2(NODE_SLOTS + 1);
    localparam int DEPTH_W    = $clog2(MAX_DEPTH);
    localparam int PARENT_W   = 8;
    localparam int COUNT_W    = 9;
    localparam int BIN_MAX    = (1 << COUNT_W) - 1;
    localparam int ROW_W      = PARENT_W + 2;

    // depths and bins share one ram, bins sit above the node slots
    localparam int BIN_BASE    = 1 << NODE_W;
    localparam int STORE_DEPTH = BIN_BASE + MAX_DEPTH;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE_RD,
        ST_DEP_RD,
        ST_DEP_WR,
        ST_BIN_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

endpackage

>>> rtl/core/huffman_code_length_histogram.sv
// huffman code length histogram: node loader, depth walker and bin emitter
// depends on hcl_pkg and hcl_ram
//
// usage: internal nodes of a huffman tree arrive on the input channel, one
// beat per node in ascending index order, each with its parent index and two
// leaf flags. a non-final beat is stored while a node slot is free and gives
// no output. the beat with final_node set is the root; it closes the run and
// starts the walk from root-1 down to node 0. each walked node is handled in
// order: read its row, read its parent's depth, write its own depth and read
// the bin, then write the bin back if the node has a leaf. accesses go through
// the node ram and a shared depth and bin ram, one read and one write per ram
// per cycle, so the walk loop sets the rate.
// after the walk, all MAX_DEPTH bins leave on the output channel, each read
// from the ram and then loaded into the output register; last_bin marks the
// final one. in_stall stays high from the final beat until the last bin is
// loaded into the output register. a stalled output holds its beat and the
// emitter waits. after reset no nodes are loaded and the output is empty; the
// rams need no clearing pass, bins use flip-flop valid bits cleared per run.
module huffman_code_length_histogram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hcl_pkg::PARENT_W-1:0]  parent_node,
    input  logic                          left_is_symbol,
    input  logic                          right_is_symbol,
    input  logic                          final_node,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [5:0]                    code_length,
    output logic [hcl_pkg::COUNT_W-1:0]   symbol_count,
    output logic                          last_bin,
    output logic                          depth_overflow
);

    hcl_pkg::state_t state_reg, state_next;

    logic [hcl_pkg::LOAD_W-1:0]    nodes_loaded_reg, nodes_loaded_next;
    logic [hcl_pkg::NODE_W-1:0]    node_reg, node_next;
    logic [1:0]                    flags_reg, flags_next;
    logic                          oor_reg, oor_next;
    logic [hcl_pkg::DEPTH_W-1:0]   depth_reg, depth_next;
    logic [hcl_pkg::MAX_DEPTH-1:0] bin_vld_reg, bin_vld_next;
    logic                          ovf_reg, ovf_next;
    logic [hcl_pkg::DEPTH_W-1:0]   emit_idx_reg, emit_idx_next;

    logic                          out_valid_reg, out_valid_next;
    logic [5:0]                    code_length_reg, code_length_next;
    logic [hcl_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          last_reg, last_next;
    logic                          ovf_out_reg, ovf_out_next;

    // ram ports
    logic                          node_we, node_re;
    logic [hcl_pkg::NODE_W-1:0]    node_waddr, node_raddr;
    logic [hcl_pkg::ROW_W-1:0]     node_wdata, node_rdata;
    logic                          st_we, st_re;
    logic [hcl_pkg::STORE_AW-1:0]  st_waddr, st_raddr;
    logic [hcl_pkg::COUNT_W-1:0]   st_wdata, st_rdata;
    logic [hcl_pkg::DEPTH_W-1:0]   dep_rdata;
    logic [hcl_pkg::COUNT_W-1:0]   bin_rdata;

    logic                          in_fire;
    logic                          slot_free;
    logic [hcl_pkg::NODE_W-1:0]    root_idx;
    logic [hcl_pkg::PARENT_W-1:0]  row_parent;
    logic [hcl_pkg::DEPTH_W-1:0]   parent_depth;
    logic [hcl_pkg::DEPTH_W-1:0]   depth_calc;
    logic                          depth_sat;
    logic [hcl_pkg::COUNT_W-1:0]   bin_cur;
    logic [hcl_pkg::COUNT_W:0]     bin_sum;
    logic [hcl_pkg::COUNT_W-1:0]   bin_sat;
    logic [1:0]                    leaf_add;

    hcl_ram #(.WIDTH(hcl_pkg::ROW_W), .DEPTH(hcl_pkg::NODE_SLOTS)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    hcl_ram #(.WIDTH(hcl_pkg::COUNT_W), .DEPTH(hcl_pkg::STORE_DEPTH)) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign in_stall  = (state_reg != hcl_pkg::ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    assign root_idx = (32'(nodes_loaded_reg) < 32'(hcl_pkg::NODE_SLOTS))
                    ? nodes_loaded_reg[hcl_pkg::NODE_W-1:0]
                    : hcl_pkg::NODE_W'(hcl_pkg::NODE_SLOTS - 1);

    assign dep_rdata    = st_rdata[hcl_pkg::DEPTH_W-1:0];
    assign bin_rdata    = st_rdata;
    assign row_parent   = node_rdata[hcl_pkg::ROW_W-1:2];
    assign parent_depth = oor_reg ? '0 : dep_rdata;
    assign depth_sat    = (32'(parent_depth) >= 32'(hcl_pkg::MAX_DEPTH - 1));
    assign depth_calc   = depth_sat ? hcl_pkg::DEPTH_W'(hcl_pkg::MAX_DEPTH - 1)
                                    : parent_depth + hcl_pkg::DEPTH_W'(1);
    assign leaf_add     = {1'b0, flags_reg[1]} + {1'b0, flags_reg[0]};
    assign bin_cur      = bin_vld_reg[depth_reg] ? bin_rdata : '0;
    assign bin_sum      = {1'b0, bin_cur} + (hcl_pkg::COUNT_W + 1)'(leaf_add);
    assign bin_sat      = (32'(bin_sum) > hcl_pkg::BIN_MAX)
                        ? hcl_pkg::COUNT_W'(hcl_pkg::BIN_MAX)
                        : bin_sum[hcl_pkg::COUNT_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hcl_pkg::ST_IDLE:
            begin
                if (in_fire && final_node)
                begin
                    state_next = (root_idx == '0) ? hcl_pkg::ST_EMIT_RD : hcl_pkg::ST_NODE_RD;
                end
            end
            hcl_pkg::ST_NODE_RD: state_next = hcl_pkg::ST_DEP_RD;
            hcl_pkg::ST_DEP_RD:  state_next = hcl_pkg::ST_DEP_WR;
            hcl_pkg::ST_DEP_WR:  state_next = hcl_pkg::ST_BIN_WR;
            hcl_pkg::ST_BIN_WR:
            begin
                state_next = (node_reg == '0) ? hcl_pkg::ST_EMIT_RD : hcl_pkg::ST_NODE_RD;
            end
            hcl_pkg::ST_EMIT_RD: state_next = hcl_pkg::ST_EMIT_LD;
            hcl_pkg::ST_EMIT_LD:
            begin
                if (slot_free)
                begin
                    state_next = (32'(emit_idx_reg) == hcl_pkg::MAX_DEPTH - 1)
                               ? hcl_pkg::ST_IDLE : hcl_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = hcl_pkg::ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        nodes_loaded_next = nodes_loaded_reg;
        node_next         = node_reg;
        flags_next        = flags_reg;
        oor_next          = oor_reg;
        depth_next        = depth_reg;
        bin_vld_next      = bin_vld_reg;
        ovf_next          = ovf_reg;
        emit_idx_next     = emit_idx_reg;

        out_valid_next    = out_valid_reg && out_stall;
        code_length_next  = code_length_reg;
        count_next        = count_reg;
        last_next         = last_reg;
        ovf_out_next      = ovf_out_reg;

        node_we    = 1'b0;
        node_waddr = nodes_loaded_reg[hcl_pkg::NODE_W-1:0];
        node_wdata = {parent_node, left_is_symbol, right_is_symbol};
        node_re    = 1'b0;
        node_raddr = node_reg;
        st_we      = 1'b0;
        st_waddr   = hcl_pkg::STORE_AW'(node_reg);
        st_wdata   = hcl_pkg::COUNT_W'(depth_calc);
        st_re      = 1'b0;
        st_raddr   = hcl_pkg::STORE_AW'(row_parent);

        case (state_reg)
            hcl_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (32'(nodes_loaded_reg) < 32'(hcl_pkg::NODE_SLOTS))
                    begin
                        node_we           = 1'b1;
                        nodes_loaded_next = nodes_loaded_reg + hcl_pkg::LOAD_W'(1);
                    end
                    if (final_node)
                    begin
                        // root depth is one; start a fresh histogram
                        st_we             = 1'b1;
                        st_waddr          = hcl_pkg::STORE_AW'(root_idx);
                        st_wdata          = hcl_pkg::COUNT_W'(1);
                        nodes_loaded_next = '0;
                        bin_vld_next      = '0;
                        ovf_next          = 1'b0;
                        node_next         = root_idx - hcl_pkg::NODE_W'(1);
                        emit_idx_next     = '0;
                    end
                end
            end
            hcl_pkg::ST_NODE_RD:
            begin
                node_re = 1'b1;
            end
            hcl_pkg::ST_DEP_RD:
            begin
                flags_next = node_rdata[1:0];
                oor_next   = (32'(row_parent) >= 32'(hcl_pkg::NODE_SLOTS));
                st_re      = 1'b1;
            end
            hcl_pkg::ST_DEP_WR:
            begin
                st_we      = 1'b1;
                depth_next = depth_calc;
                st_re      = 1'b1;
                st_raddr   = hcl_pkg::STORE_AW'(hcl_pkg::BIN_BASE)
                           + hcl_pkg::STORE_AW'(depth_calc);
                if (depth_sat)
                begin
                    ovf_next = 1'b1;
                end
            end
            hcl_pkg::ST_BIN_WR:
            begin
                if (leaf_add != 2'd0)
                begin
                    st_we                   = 1'b1;
                    st_waddr                = hcl_pkg::STORE_AW'(hcl_pkg::BIN_BASE)
                                            + hcl_pkg::STORE_AW'(depth_reg);
                    st_wdata                = bin_sat;
                    bin_vld_next[depth_reg] = 1'b1;
                end
                node_next = node_reg - hcl_pkg::NODE_W'(1);
            end
            hcl_pkg::ST_EMIT_RD:
            begin
                st_re    = 1'b1;
                st_raddr = hcl_pkg::STORE_AW'(hcl_pkg::BIN_BASE)
                         + hcl_pkg::STORE_AW'(emit_idx_reg);
            end
            hcl_pkg::ST_EMIT_LD:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    code_length_next = 6'(emit_idx_reg);
                    count_next       = bin_vld_reg[emit_idx_reg] ? bin_rdata : '0;
                    last_next        = (32'(emit_idx_reg) == hcl_pkg::MAX_DEPTH - 1);
                    ovf_out_next     = ovf_reg;
                    emit_idx_next    = emit_idx_reg + hcl_pkg::DEPTH_W'(1);
                end
            end
            default:
            begin
                node_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hcl_pkg::ST_IDLE;
            nodes_loaded_reg <= '0;
            bin_vld_reg      <= '0;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            emit_idx_reg     <= '0;
            node_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            nodes_loaded_reg <= nodes_loaded_next;
            bin_vld_reg      <= bin_vld_next;
            ovf_reg          <= ovf_next;
            out_valid_reg    <= out_valid_next;
            emit_idx_reg     <= emit_idx_next;
            node_reg         <= node_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg       <= flags_next;
        oor_reg         <= oor_next;
        depth_reg       <= depth_next;
        code_length_reg <= code_length_next;
        count_reg       <= count_next;
        last_reg        <= last_next;
        ovf_out_reg     <= ovf_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign code_length    = code_length_reg;
    assign symbol_count   = count_reg;
    assign last_bin       = last_reg;
    assign depth_overflow = ovf_out_reg;

    // a new beat on the output only comes from the emitter
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == hcl_pkg::ST_EMIT_LD))
        else $error("output beat appeared outside emission");

    // walked nodes always sit at depth one or more
    a_depth_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hcl_pkg::ST_BIN_WR) |-> (depth_reg != '0))
        else $error("walked node has depth zero");

    // bin zero is never updated
    a_bin0_unused: assert property (@(posedge clk) disable iff (!rst_n)
        !bin_vld_reg[0])
        else $error("bin zero was written");

    // load count never passes the store size
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(nodes_loaded_reg) <= 32'(hcl_pkg::NODE_SLOTS))
        else $error("node count beyond store size");

endmodule

>>> rtl/core/hcl_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module hcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> tb/huffman_code_length_histogram_tb.sv
// self-checking testbench for huffman_code_length_histogram: feeds huffman trees
// node by node and checks every emitted code length bin against a local walker
// depends on hcl_pkg and the rtl of the block
`timescale 1ns / 1ps

module huffman_code_length_histogram_tb;

    localparam int SLOTS = hcl_pkg::NODE_SLOTS;
    localparam int BINS  = hcl_pkg::MAX_DEPTH;
    localparam int NPLAN = 18;

    typedef struct packed {
        logic [5:0]                  len;
        logic [hcl_pkg::COUNT_W-1:0] cnt;
        logic                        last;
        logic                        ovf;
    } bin_beat_t;

    typedef struct packed {
        logic [7:0] par;
        logic       ls;
        logic       rs;
        logic       fin;
        logic       typed;
        logic [5:0] bin;
        logic [8:0] cnt;
    } row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [hcl_pkg::PARENT_W-1:0]  parent_node;
    logic                          left_is_symbol;
    logic                          right_is_symbol;
    logic                          final_node;
    logic                          out_valid;
    logic                          out_stall;
    logic [5:0]                    code_length;
    logic [hcl_pkg::COUNT_W-1:0]   symbol_count;
    logic                          last_bin;
    logic                          depth_overflow;

    logic [7:0] tree_parent [SLOTS];
    logic [1:0] tree_leaves [SLOTS];
    logic [5:0] model_depth [SLOTS];
    bit         depth_known [SLOTS];
    int         nodes_held = 0;
    int         hist [BINS];
    bit         hist_ovf;

    bin_beat_t bins_due [$];

    int mismatches    = 0;
    int beats_checked = 0;
    int items_fed     = 0;
    int trees_done    = 0;
    int overflow_runs = 0;
    int gap_pct       = 0;
    int stall_pct     = 0;
    int stall_left    = 0;
    bit calm          = 1'b0;

    // root only, single leaf pair, parent out of range, stale depth, no leaves, mixed
    row_t plan [NPLAN] = '{
        '{8'd0,   1'b1, 1'b1, 1'b1, 1'b1, 6'd0, 9'd0},
        '{8'd1,   1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd255, 1'b1, 1'b1, 1'b1, 1'b1, 6'd2, 9'd2},
        '{8'd255, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd0,   1'b0, 1'b0, 1'b1, 1'b1, 6'd1, 9'd1},
        '{8'd2,   1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd0,   1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd128, 1'b1, 1'b1, 1'b1, 1'b0, 6'd0, 9'd0},
        '{8'd1,   1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd2,   1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd3,   1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd127, 1'b0, 1'b0, 1'b1, 1'b1, 6'd0, 9'd0},
        '{8'd5,   1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd5,   1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd4,   1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd4,   1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd5,   1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 9'd0},
        '{8'd64,  1'b1, 1'b1, 1'b1, 1'b0, 6'd0, 9'd0}
    };

    huffman_code_length_histogram dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .parent_node     (parent_node),
        .left_is_symbol  (left_is_symbol),
        .right_is_symbol (right_is_symbol),
        .final_node      (final_node),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .code_length     (code_length),
        .symbol_count    (symbol_count),
        .last_bin        (last_bin),
        .depth_overflow  (depth_overflow)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic build_histogram(input logic [7:0] par, input logic ls, input logic rs,
                                   input logic fin, output bit produced);
        int root;
        int k;
        int pd;
        int d;
        int cnt;
        if (nodes_held < SLOTS)
        begin
            root = nodes_held;
            tree_parent[root] = par;
            tree_leaves[root] = {ls, rs};
            nodes_held++;
        end
        else
        begin
            root = SLOTS - 1;
        end
        produced = fin;
        if (fin)
        begin
            for (k = 0; k < BINS; k++)
                hist[k] = 0;
            hist_ovf = 1'b0;
            model_depth[root] = 6'd1;
            depth_known[root] = 1'b1;
            for (k = root - 1; k >= 0; k--)
            begin
                pd = (tree_parent[k] >= SLOTS) ? 0 : int'(model_depth[tree_parent[k]]);
                if (pd >= BINS - 1)
                begin
                    d = BINS - 1;
                    hist_ovf = 1'b1;
                end
                else
                begin
                    d = pd + 1;
                end
                model_depth[k] = d[5:0];
                depth_known[k] = 1'b1;
                cnt = hist[d] + tree_leaves[k][1] + tree_leaves[k][0];
                hist[d] = (cnt > hcl_pkg::BIN_MAX) ? hcl_pkg::BIN_MAX : cnt;
            end
            nodes_held = 0;
            trees_done++;
            if (hist_ovf)
                overflow_runs++;
        end
    endtask

    task automatic push_model_bins();
        bin_beat_t beat;
        int k;
        for (k = 0; k < BINS; k++)
        begin
            beat.len  = k[5:0];
            beat.cnt  = hist[k][hcl_pkg::COUNT_W-1:0];
            beat.last = (k == BINS - 1);
            beat.ovf  = hist_ovf;
            bins_due.push_back(beat);
        end
    endtask

    task automatic feed_node(input logic [7:0] par, input logic ls, input logic rs,
                             input logic fin, output bit produced);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        parent_node     <= par;
        left_is_symbol  <= ls;
        right_is_symbol <= rs;
        final_node      <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        build_histogram(par, ls, rs, fin, produced);
        items_fed++;
    endtask

    task automatic wait_for_bins();
        if (bins_due.size() != 0)
        begin
            in_valid <= 1'b0;
            while (bins_due.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic pick_pace();
        int sel;
        sel = $urandom_range(3);
        gap_pct   = calm ? 0 : (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
        sel = $urandom_range(3);
        stall_pct = calm ? 0 : (sel == 0) ? 0 : (sel == 1) ? 8 : 30;
    endtask

    // nodes counts stored entries including the root; extras follow a full store
    task automatic send_tree(input int nodes, input bit chain, input int extras);
        int root;
        int i;
        int p;
        int alt;
        int sel;
        bit produced;
        root = nodes - 1;
        for (i = 0; i <= root; i++)
        begin
            if (i == root)
                p = $urandom_range(255);
            else if (chain)
                p = i + 1;
            else
            begin
                sel = $urandom_range(99);
                if (sel < 4)
                    p = 255;
                else
                begin
                    p = $urandom_range(root, i + 1);
                    // depth left over from an earlier tree
                    if (sel < 12)
                    begin
                        alt = $urandom_range(SLOTS - 1);
                        if (depth_known[alt])
                            p = alt;
                    end
                end
            end
            feed_node(p[7:0], 1'($urandom_range(1)), 1'($urandom_range(1)),
                      (i == root) && (extras == 0), produced);
        end
        for (i = 0; i < extras; i++)
        begin
            feed_node(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      i == extras - 1, produced);
        end
        if (produced)
            push_model_bins();
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_bin_beat();
        bin_beat_t want;
        if (bins_due.size() == 0)
        begin
            flag_mismatch("beat with nothing due, code_length", code_length, -1);
        end
        else
        begin
            want = bins_due.pop_front();
            if (code_length !== want.len)
                flag_mismatch("code_length", code_length, want.len);
            if (symbol_count !== want.cnt)
                flag_mismatch("symbol_count", symbol_count, want.cnt);
            if (last_bin !== want.last)
                flag_mismatch("last_bin", last_bin, want.last);
            if (depth_overflow !== want.ovf)
                flag_mismatch("depth_overflow", depth_overflow, want.ovf);
            beats_checked++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_bin_beat();
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(12);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int r;
        int size;
        int start_items;
        bit produced;
        bin_beat_t beat;
        int k;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        parent_node     = '0;
        left_is_symbol  = 1'b0;
        right_is_symbol = 1'b0;
        final_node      = 1'b0;
        out_stall       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        gap_pct   = 30;
        stall_pct = 20;
        for (r = 0; r < NPLAN; r++)
        begin
            feed_node(plan[r].par, plan[r].ls, plan[r].rs, plan[r].fin, produced);
            if (produced && plan[r].typed)
            begin
                for (k = 0; k < BINS; k++)
                begin
                    beat.len  = k[5:0];
                    beat.cnt  = (k == plan[r].bin) ? plan[r].cnt : '0;
                    beat.last = (k == BINS - 1);
                    beat.ovf  = 1'b0;
                    bins_due.push_back(beat);
                end
            end
            else if (produced)
            begin
                push_model_bins();
            end
        end
        wait_for_bins();

        // deepest legal chain, then the first saturating chain
        pick_pace();
        send_tree(BINS - 1, 1'b1, 0);
        pick_pace();
        send_tree(BINS, 1'b1, 0);
        wait_for_bins();

        start_items = items_fed;
        while (items_fed - start_items < 36)
        begin
            calm = (items_fed - start_items >= 26);
            pick_pace();
            r = $urandom_range(99);
            if (r < 15)
                size = 1;
            else if (r < 80)
                size = $urandom_range(8, 2);
            else
                size = $urandom_range(20, 9);
            send_tree(size, $urandom_range(9) == 0, 0);
            if (!calm && $urandom_range(5) == 0)
                wait_for_bins();
        end

        in_valid <= 1'b0;
        while (bins_due.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("covered %0d trees from %0d node beats, %0d with depth overflow",
                 trees_done, items_fed, overflow_runs);
        $display("checked %0d code length bins", beats_checked);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
